[design/npg_pkg.sv]
// shared types and constants for the next permutation generator
`timescale 1ns / 1ps

package npg_pkg;

   localparam int INDEX_W    = 4;
   localparam int VALUE_W    = 8;
   localparam int LENGTH_W   = 5;
   localparam int POSITION_W = 4;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 5'd16;
   localparam logic [LENGTH_W-1:0] LENGTH_MIN   = 5'd2;

   typedef struct packed {
      logic                  valid;
      logic [POSITION_W-1:0] position;
      logic [VALUE_W-1:0]    element;
      logic                  last;
      logic                  wrapped;
   } emit_type;

endpackage

[design/npg_store.sv]
// sequence store: one write port, two registered read ports, reset-cleared valid bits
`timescale 1ns / 1ps

module npg_store #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [IDX_W-1:0]            rd_a_addr,
   input  logic [IDX_W-1:0]            rd_b_addr,
   output logic [npg_pkg::VALUE_W-1:0] rd_a_data,
   output logic [npg_pkg::VALUE_W-1:0] rd_b_data,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic [npg_pkg::VALUE_W-1:0] wr_data
);
   import npg_pkg::*;

   logic [VALUE_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]   valid_ff;
   logic [VALUE_W-1:0] rd_a_data_ff;
   logic [VALUE_W-1:0] rd_b_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      rd_a_data_ff <= valid_ff[rd_a_addr] ? mem_ff[rd_a_addr] : '0;
      rd_b_data_ff <= valid_ff[rd_b_addr] ? mem_ff[rd_b_addr] : '0;
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule

[design/npg_ctrl.sv]
// sequencer: pivot search, successor search, swap, tail reversal and emit over a shared comparator
`timescale 1ns / 1ps

module npg_ctrl #(
   parameter int MAX_LEN = 16,
   parameter int IDX_W   = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_operation,
   input  logic [npg_pkg::INDEX_W-1:0]  req_index,
   input  logic [npg_pkg::VALUE_W-1:0]  req_value,
   input  logic                         csr_wr_en,
   input  logic [npg_pkg::LENGTH_W-1:0] csr_wr_data,
   output npg_pkg::emit_type            emit,
   input  logic                         emit_take,
   output logic [IDX_W-1:0]             rd_a_addr,
   output logic [IDX_W-1:0]             rd_b_addr,
   input  logic [npg_pkg::VALUE_W-1:0]  rd_a_data,
   input  logic [npg_pkg::VALUE_W-1:0]  rd_b_data,
   output logic                         wr_en,
   output logic [IDX_W-1:0]             wr_addr,
   output logic [npg_pkg::VALUE_W-1:0]  wr_data
);
   import npg_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PIV   = 4'd1;
   localparam logic [3:0] S_SUC   = 4'd2;
   localparam logic [3:0] S_SWPA  = 4'd3;
   localparam logic [3:0] S_SWPB  = 4'd4;
   localparam logic [3:0] S_REVR  = 4'd5;
   localparam logic [3:0] S_REVA  = 4'd6;
   localparam logic [3:0] S_REVB  = 4'd7;
   localparam logic [3:0] S_EMITR = 4'd8;
   localparam logic [3:0] S_EMITW = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [LENGTH_W-1:0] act_len_ff, act_len_in;
   logic [IDX_W-1:0]    last_ff, last_in;
   logic [IDX_W-1:0]    k_ff, k_in;
   logic [IDX_W-1:0]    kd_ff, kd_in;
   logic                chk_ff, chk_in;
   logic [IDX_W-1:0]    piv_ff, piv_in;
   logic [VALUE_W-1:0]  piv_val_ff, piv_val_in;
   logic [IDX_W-1:0]    suc_ff, suc_in;
   logic [VALUE_W-1:0]  suc_val_ff, suc_val_in;
   logic [IDX_W-1:0]    lo_ff, lo_in;
   logic [IDX_W-1:0]    hi_ff, hi_in;
   logic [IDX_W-1:0]    e_ff, e_in;
   logic                wrap_ff, wrap_in;

   logic [IDX_W-1:0]    eff_last;
   logic [VALUE_W-1:0]  cmp_lhs;
   logic                less;
   logic                req_accept;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   // shared comparator
   assign cmp_lhs = (state_ff == S_SUC) ? piv_val_ff : rd_a_data;
   assign less    = (cmp_lhs < rd_b_data);

   // clamp of the active length, kept as its last index
   always_comb begin
      if (act_len_ff < LENGTH_MIN) begin
         eff_last = IDX_W'(1);
      end else if (32'(act_len_ff) > MAX_LEN) begin
         eff_last = IDX_W'(MAX_LEN - 1);
      end else begin
         eff_last = IDX_W'(act_len_ff - 5'd1);
      end
   end

   always_comb begin
      state_in   = state_ff;
      act_len_in = csr_wr_en ? csr_wr_data : act_len_ff;
      last_in    = last_ff;
      k_in       = k_ff;
      kd_in      = kd_ff;
      chk_in     = chk_ff;
      piv_in     = piv_ff;
      piv_val_in = piv_val_ff;
      suc_in     = suc_ff;
      suc_val_in = suc_val_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      e_in       = e_ff;
      wrap_in    = wrap_ff;
      rd_a_addr  = '0;
      rd_b_addr  = '0;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      emit       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_operation == OP_LOAD) begin
                  wr_en   = (32'(req_index) < MAX_LEN);
                  wr_addr = IDX_W'(req_index);
                  wr_data = req_value;
               end else begin
                  last_in  = eff_last;
                  k_in     = eff_last;
                  chk_in   = 1'b0;
                  state_in = S_PIV;
               end
            end
         end
         S_PIV: begin
            rd_a_addr = k_ff - IDX_W'(1);
            rd_b_addr = k_ff;
            kd_in     = k_ff;
            chk_in    = 1'b1;
            if (k_ff > IDX_W'(1)) begin
               k_in = k_ff - IDX_W'(1);
            end
            if (chk_ff) begin
               if (less) begin
                  piv_in     = kd_ff - IDX_W'(1);
                  piv_val_in = rd_a_data;
                  wrap_in    = 1'b0;
                  k_in       = last_ff;
                  chk_in     = 1'b0;
                  state_in   = S_SUC;
               end else if (kd_ff == IDX_W'(1)) begin
                  wrap_in  = 1'b1;
                  lo_in    = '0;
                  hi_in    = last_ff;
                  state_in = S_REVR;
               end
            end
         end
         S_SUC: begin
            rd_b_addr = k_ff;
            kd_in     = k_ff;
            chk_in    = 1'b1;
            if (k_ff != '0) begin
               k_in = k_ff - IDX_W'(1);
            end
            if (chk_ff && less) begin
               suc_in     = kd_ff;
               suc_val_in = rd_b_data;
               state_in   = S_SWPA;
            end
         end
         S_SWPA: begin
            wr_en    = 1'b1;
            wr_addr  = piv_ff;
            wr_data  = suc_val_ff;
            state_in = S_SWPB;
         end
         S_SWPB: begin
            wr_en    = 1'b1;
            wr_addr  = suc_ff;
            wr_data  = piv_val_ff;
            lo_in    = piv_ff + IDX_W'(1);
            hi_in    = last_ff;
            state_in = S_REVR;
         end
         S_REVR: begin
            rd_a_addr = lo_ff;
            rd_b_addr = hi_ff;
            if (lo_ff < hi_ff) begin
               state_in = S_REVA;
            end else begin
               e_in     = '0;
               state_in = S_EMITR;
            end
         end
         S_REVA: begin
            rd_a_addr = lo_ff;
            rd_b_addr = hi_ff;
            wr_en     = 1'b1;
            wr_addr   = lo_ff;
            wr_data   = rd_b_data;
            state_in  = S_REVB;
         end
         S_REVB: begin
            rd_a_addr = lo_ff;
            rd_b_addr = hi_ff;
            wr_en     = 1'b1;
            wr_addr   = hi_ff;
            wr_data   = rd_a_data;
            lo_in     = lo_ff + IDX_W'(1);
            hi_in     = hi_ff - IDX_W'(1);
            state_in  = S_REVR;
         end
         S_EMITR: begin
            rd_a_addr = e_ff;
            state_in  = S_EMITW;
         end
         S_EMITW: begin
            rd_a_addr     = e_ff;
            emit.valid    = 1'b1;
            emit.position = POSITION_W'(e_ff);
            emit.element  = rd_a_data;
            emit.last     = (e_ff == last_ff);
            emit.wrapped  = wrap_ff;
            if (emit_take) begin
               if (e_ff == last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  e_in     = e_ff + IDX_W'(1);
                  state_in = S_EMITR;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         act_len_ff <= LENGTH_RESET;
         chk_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         act_len_ff <= act_len_in;
         chk_ff     <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff    <= last_in;
      k_ff       <= k_in;
      kd_ff      <= kd_in;
      piv_ff     <= piv_in;
      piv_val_ff <= piv_val_in;
      suc_ff     <= suc_in;
      suc_val_ff <= suc_val_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      e_ff       <= e_in;
      wrap_ff    <= wrap_in;
   end

`ifndef NO_ASSERTIONS
   a_adv_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_operation == OP_ADVANCE) |=> state_ff == S_PIV)
      else $error("advance did not start the pivot scan");

   a_piv_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PIV) && chk_ff |-> (kd_ff != '0) && (kd_ff <= last_ff))
      else $error("pivot scan index out of range");

   a_suc_right_of_pivot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUC) && chk_ff |-> kd_ff > piv_ff)
      else $error("successor search passed the pivot");

   a_rev_ordered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REVA) || (state_ff == S_REVB) |-> lo_ff < hi_ff)
      else $error("reversal pointers crossed");

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> (e_ff <= last_ff) && !wr_en)
      else $error("emit beyond active length or during a write");
`endif

endmodule

[design/next_permutation_generator.sv]
// top level of the lexicographic next permutation generator
`timescale 1ns / 1ps

// Holds up to MAX_LEN byte elements; the first active_length (clamped to 2..MAX_LEN)
// take part. A load beat writes one element and gives no response.
// An advance beat rearranges the active elements into their next lexicographic
// permutation (after the final one it returns to ascending order and flags wrapped)
// and then sends every active element in order, last marking the final one.
// One compare unit and one store write port are stepped by a sequencer, one element
// per cycle in the scans; the reversal reads, then writes the low and the high element
// of each swapped pair, and each emitted element is read and then offered, held while
// the response output stalls. No request is taken meanwhile.
module next_permutation_generator #(
   parameter int MAX_LEN = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_operation,
   input  logic [npg_pkg::INDEX_W-1:0]    req_index,
   input  logic [npg_pkg::VALUE_W-1:0]    req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [npg_pkg::POSITION_W-1:0] rsp_position,
   output logic [npg_pkg::VALUE_W-1:0]    rsp_element,
   output logic                           rsp_last,
   output logic                           rsp_wrapped,
   input  logic                           csr_wr_en,
   input  logic [npg_pkg::LENGTH_W-1:0]   csr_wr_data
);
   import npg_pkg::*;

   localparam int IDX_W = $clog2(MAX_LEN);

   emit_type            emit;
   logic                emit_take;
   logic [IDX_W-1:0]    rd_a_addr;
   logic [IDX_W-1:0]    rd_b_addr;
   logic [VALUE_W-1:0]  rd_a_data;
   logic [VALUE_W-1:0]  rd_b_data;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [VALUE_W-1:0]  wr_data;

   logic                  rsp_valid_ff;
   logic [POSITION_W-1:0] rsp_position_ff;
   logic [VALUE_W-1:0]    rsp_element_ff;
   logic                  rsp_last_ff;
   logic                  rsp_wrapped_ff;

   npg_store #(
      .DEPTH (MAX_LEN),
      .IDX_W (IDX_W)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   npg_ctrl #(
      .MAX_LEN (MAX_LEN),
      .IDX_W   (IDX_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_index     (req_index),
      .req_value     (req_value),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .emit          (emit),
      .emit_take     (emit_take),
      .rd_a_addr     (rd_a_addr),
      .rd_b_addr     (rd_b_addr),
      .rd_a_data     (rd_a_data),
      .rd_b_data     (rd_b_data),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data)
   );

   // response output register
   assign emit_take = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_take) begin
         rsp_valid_ff <= emit.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_take && emit.valid) begin
         rsp_position_ff <= emit.position;
         rsp_element_ff  <= emit.element;
         rsp_last_ff     <= emit.last;
         rsp_wrapped_ff  <= emit.wrapped;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_element  = rsp_element_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_wrapped  = rsp_wrapped_ff;

endmodule
